// ===== rtl/tkpc_pkg.sv =====
// Touch key press classifier: shared types and constants.
// Depends on nothing; imported by the lane, merge and top-level modules.
`timescale 1ns / 1ps

package tkpc_pkg;

    localparam int TIME_W   = 32;
    localparam int BITS_W   = 8;
    localparam int KIDX_W   = 3;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_KEY_BIT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN_TIME  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX_TIME  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TIME = 8'd3;

    // Reset values
    localparam logic [KIDX_W-1:0] RST_FIRST_KEY_BIT   = 3'd3;
    localparam logic [TIME_W-1:0] RST_SHORT_MIN_TIME  = 32'd1;
    localparam logic [TIME_W-1:0] RST_SHORT_MAX_TIME  = 32'd1000;
    localparam logic [TIME_W-1:0] RST_LONG_PRESS_TIME = 32'd2500;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_HELD     = 2'd2,
        EV_RELEASED = 2'd3
    } t_event;

    typedef struct packed {
        logic [KIDX_W-1:0] first_key_bit;
        logic [TIME_W-1:0] short_min_time;
        logic [TIME_W-1:0] short_max_time;
        logic [TIME_W-1:0] long_press_time;
    } t_cfg;

    typedef struct packed {
        logic [KIDX_W-1:0] key_index;
        logic              touched;
        t_event            event_kind;
        logic [TIME_W-1:0] touch_duration;
        logic              short_press;
        logic              long_press;
        logic              constant_press;
        logic              timer_in_use;
        logic              last_key;
    } t_key_result;

endpackage

// ===== rtl/tkpc_if.sv =====
// Touch key press classifier: valid/ready channel interfaces.
// Depends on tkpc_pkg for field widths and the event type.
`timescale 1ns / 1ps

interface tkpc_scan_if;
    logic                           valid;
    logic                           ready;
    logic [tkpc_pkg::BITS_W-1:0]    sensor_bits;
    logic [tkpc_pkg::TIME_W-1:0]    reference_time;

    modport source (output valid, sensor_bits, reference_time, input ready);
    modport sink   (input valid, sensor_bits, reference_time, output ready);
endinterface

interface tkpc_result_if;
    logic                           valid;
    logic                           ready;
    logic [tkpc_pkg::KIDX_W-1:0]    key_index;
    logic                           touched;
    tkpc_pkg::t_event               event_kind;
    logic [tkpc_pkg::TIME_W-1:0]    touch_duration;
    logic                           short_press;
    logic                           long_press;
    logic                           constant_press;
    logic                           timer_in_use;
    logic                           last_key;

    modport source (output valid, key_index, touched, event_kind, touch_duration,
                    short_press, long_press, constant_press, timer_in_use, last_key,
                    input ready);
    modport sink   (input valid, key_index, touched, event_kind, touch_duration,
                    short_press, long_press, constant_press, timer_in_use, last_key,
                    output ready);
endinterface

interface tkpc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tkpc_pkg::CFG_IDX_W-1:0]   index;
    logic [tkpc_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/touch_key_press_classifier.sv =====
// Touch key press classifier: top level with config registers and key lanes.
// Depends on tkpc_pkg, tkpc_if, tkpc_lane and tkpc_merge.
//
// Usage:
//   i_scan   - one word per scan: sensor status byte and 32-bit timestamp.
//   o_result - NUM_KEYS words per scan, key 0 first; last_key marks the
//              final word of the scan.
//   i_cfg    - register writes (index, data); always ready. Index 0 first
//              key bit, 1 short minimum, 2 short maximum, 3 long threshold;
//              other indexes are dropped. Write only while the block is idle.
// Latency: the first word of a scan is valid the cycle after the scan is
//   taken; the rest follow one per cycle while the receiver is ready.
// Throughput: each scan's words leave through the single result port that
//   drains the per-scan buffer. All lanes classify a scan in the cycle it
//   is accepted, so a new scan is taken in the same cycle as the last word
//   of the previous one leaves.
// Reset (synchronous, active low): all key state cleared, registers back to
//   first bit 3, minimum 1, maximum 1000, long threshold 2500; no words pending.
// Stall: while o_result is not taken the buffer holds its word and i_scan
//   ready stays low once the previous scan's words are not all gone.
`timescale 1ns / 1ps

module touch_key_press_classifier #(
    parameter int NUM_KEYS = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tkpc_scan_if.sink      i_scan,
    tkpc_result_if.source  o_result,
    tkpc_cfg_if.sink       i_cfg
);
    import tkpc_pkg::*;

    t_cfg r_cfg;
    logic in_fire;
    logic merge_free;

    t_key_result         lane_res [NUM_KEYS];
    logic [NUM_KEYS-1:0] lane_timing;

    // configuration registers; writes never stall
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_key_bit   <= RST_FIRST_KEY_BIT;
            r_cfg.short_min_time  <= RST_SHORT_MIN_TIME;
            r_cfg.short_max_time  <= RST_SHORT_MAX_TIME;
            r_cfg.long_press_time <= RST_LONG_PRESS_TIME;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FIRST_KEY_BIT:   r_cfg.first_key_bit   <= i_cfg.data[KIDX_W-1:0];
                CFG_SHORT_MIN_TIME:  r_cfg.short_min_time  <= i_cfg.data[TIME_W-1:0];
                CFG_SHORT_MAX_TIME:  r_cfg.short_max_time  <= i_cfg.data[TIME_W-1:0];
                CFG_LONG_PRESS_TIME: r_cfg.long_press_time <= i_cfg.data[TIME_W-1:0];
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // take a scan whenever the result buffer is empty or emptying
    assign i_scan.ready = merge_free;
    assign in_fire      = i_scan.valid && merge_free;

    // one lane per key, each with its own state
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        tkpc_lane #(
            .KEY (k)
        ) u_lane (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_load           (in_fire),
            .i_sensor_bits    (i_scan.sensor_bits),
            .i_reference_time (i_scan.reference_time),
            .i_cfg            (r_cfg),
            .o_result         (lane_res[k]),
            .o_timing         (lane_timing[k])
        );
    end

    // combines the lanes (timer in use, last marker) and sends one word a cycle while the receiver is ready
    tkpc_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (in_fire),
        .i_lane_res    (lane_res),
        .i_lane_timing (lane_timing),
        .o_free        (merge_free),
        .o_result      (o_result)
    );

endmodule

// ===== rtl/tkpc_lane.sv =====
// Touch key press classifier: one key lane (state, event, timing, flags).
// Depends on tkpc_pkg.
`timescale 1ns / 1ps

module tkpc_lane #(
    parameter int KEY = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [tkpc_pkg::BITS_W-1:0]   i_sensor_bits,
    input  logic [tkpc_pkg::TIME_W-1:0]   i_reference_time,
    input  tkpc_pkg::t_cfg                i_cfg,
    output tkpc_pkg::t_key_result         o_result,
    output logic                          o_timing
);
    import tkpc_pkg::*;

    logic              r_prev,    n_prev;
    logic [TIME_W-1:0] r_start,   n_start;
    logic [TIME_W-1:0] r_elapsed, n_elapsed;
    logic              r_longrep, n_longrep;
    logic              r_timing,  n_timing;

    logic [3:0]        pos;
    logic              cur;
    t_event            ev;
    logic [TIME_W-1:0] delta;
    logic              longrep_mid;
    logic              lp;

    // bit positions past the byte read as untouched
    assign pos = 4'(i_cfg.first_key_bit) + 4'(KEY);
    assign cur = pos[3] ? 1'b0 : i_sensor_bits[pos[2:0]];
    assign delta = i_reference_time - r_start;

    always_comb begin
        unique case ({r_prev, cur})
            2'b01:   ev = EV_PRESSED;
            2'b10:   ev = EV_RELEASED;
            2'b11:   ev = EV_HELD;
            default: ev = EV_NONE;
        endcase
    end

    always_comb begin
        n_prev      = cur;
        n_start     = r_start;
        n_elapsed   = r_elapsed;
        n_timing    = r_timing;
        longrep_mid = r_longrep;
        unique case (ev)
            EV_PRESSED: begin
                longrep_mid = 1'b0;
                n_timing    = 1'b1;
                n_start     = i_reference_time;
            end
            EV_HELD: begin
                if (delta != '0) n_elapsed = delta;
            end
            EV_RELEASED: begin
                if (delta != '0) n_elapsed = delta;
                n_start  = i_reference_time;
                n_timing = 1'b0;
            end
            default: begin
                n_elapsed = '0;
                n_start   = '0;
            end
        endcase
        // stale duration is still seen on a press event
        lp        = (n_elapsed > i_cfg.long_press_time) && !longrep_mid;
        n_longrep = longrep_mid | lp;
    end

    always_comb begin
        o_result.key_index      = KIDX_W'(KEY);
        o_result.touched        = cur;
        o_result.event_kind     = ev;
        o_result.touch_duration = n_elapsed;
        o_result.short_press    = (ev == EV_RELEASED) &&
                                  (n_elapsed > i_cfg.short_min_time) &&
                                  (n_elapsed < i_cfg.short_max_time);
        o_result.long_press     = lp;
        o_result.constant_press = (ev == EV_HELD) && (n_elapsed > i_cfg.short_min_time);
        o_result.timer_in_use   = n_timing;   // merged across lanes later
        o_result.last_key       = 1'b0;       // set by the merge stage
    end

    assign o_timing = n_timing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= 1'b0;
            r_start   <= '0;
            r_elapsed <= '0;
            r_longrep <= 1'b0;
            r_timing  <= 1'b0;
        end else if (i_load) begin
            r_prev    <= n_prev;
            r_start   <= n_start;
            r_elapsed <= n_elapsed;
            r_longrep <= n_longrep;
            r_timing  <= n_timing;
        end
    end

endmodule

// ===== rtl/tkpc_merge.sv =====
// Touch key press classifier: merges lane results and serialises them.
// Depends on tkpc_pkg and tkpc_result_if.
`timescale 1ns / 1ps

module tkpc_merge #(
    parameter int NUM_KEYS = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  tkpc_pkg::t_key_result   i_lane_res [NUM_KEYS],
    input  logic [NUM_KEYS-1:0]     i_lane_timing,
    output logic                    o_free,
    tkpc_result_if.source           o_result
);
    import tkpc_pkg::*;

    localparam int CNT_W = $clog2(NUM_KEYS + 1);

    t_key_result r_buf [NUM_KEYS];
    t_key_result n_buf [NUM_KEYS];
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic any_timing;
    logic out_fire;

    assign any_timing = |i_lane_timing;
    assign out_fire   = o_result.valid && o_result.ready;
    // free when empty, or once the last pending word leaves this cycle
    assign o_free = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && o_result.ready);

    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        if (i_load) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                n_buf[k]              = i_lane_res[k];
                n_buf[k].timer_in_use = any_timing;
                n_buf[k].last_key     = (k == NUM_KEYS - 1);
            end
            n_cnt = CNT_W'(NUM_KEYS);
        end else if (out_fire) begin
            for (int k = 0; k < NUM_KEYS - 1; k++) begin
                n_buf[k] = r_buf[k + 1];
            end
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    assign o_result.valid          = (r_cnt != '0);
    assign o_result.key_index      = r_buf[0].key_index;
    assign o_result.touched        = r_buf[0].touched;
    assign o_result.event_kind     = r_buf[0].event_kind;
    assign o_result.touch_duration = r_buf[0].touch_duration;
    assign o_result.short_press    = r_buf[0].short_press;
    assign o_result.long_press     = r_buf[0].long_press;
    assign o_result.constant_press = r_buf[0].constant_press;
    assign o_result.timer_in_use   = r_buf[0].timer_in_use;
    assign o_result.last_key       = r_buf[0].last_key;

endmodule
